// ----- rtl/aff_pkg.sv -----
package aff_pkg;

    // fixed field widths of the request and result channels
    localparam int ACTION_W = 3;
    localparam int ANGLE_W  = 16;
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        ACT_IDENT     = 3'd0,
        ACT_TRANSLATE = 3'd1,
        ACT_ROTATE    = 3'd2,
        ACT_SCALE     = 3'd3,
        ACT_COMPOSE   = 3'd4,
        ACT_POINT     = 3'd5
    } act_t;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MS_NONE,
        MS_T,
        MS_T2,
        MS_PX,
        MS_DIV,
        MS_S,
        MS_MAT
    } mul_sel_t;

    // what is done with the registered product
    typedef enum logic [3:0] {
        WB_NONE,
        WB_T,
        WB_T2,
        WB_X,
        WB_P,
        WB_SIN,
        WB_ROT,
        WB_ACC0,
        WB_RES,
        WB_COMMIT,
        WB_OUT,
        WB_IDENT
    } wb_sel_t;

    typedef struct packed {
        mul_sel_t   mul;
        logic [3:0] ma;
        logic [2:0] mb;
        wb_sel_t    wb;
        logic [3:0] wi;
        logic       last;
    } uop_t;

    typedef struct packed {
        logic load;
        logic push;
        uop_t uop;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_PUSH
    } ctrl_state_t;

    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] MAX_STEP = 6'd56;

    // operand codes for the point coordinates on the a side of the multiplier
    localparam logic [3:0] MA_OPX = 4'd6;
    localparam logic [3:0] MA_OPY = 4'd7;

    localparam int Q30_W    = 31;
    localparam int Q30_FRAC = 30;
    localparam logic [Q30_W-1:0] Q30_ONE    = 31'h4000_0000;
    localparam logic [33:0]      TWO_PI_Q30 = 34'd6746518852;

    localparam logic [3:0] SIN_DIV0 = 4'd0;
    localparam logic [3:0] COS_DIV0 = 4'd4;

    localparam uop_t UOP_IDLE = '{mul: MS_NONE, ma: 4'd0, mb: 3'd0, wb: WB_NONE,
                                  wi: 4'd0, last: 1'b0};

    // exact floor division of a 30 bit value by a small constant:
    // multiply by ceil(2^sh / d), then shift right by sh
    function automatic logic [30:0] recip(input logic [3:0] k);
        logic [30:0] r;
        unique case (k)
            4'd0:    r = 31'd1908874354;  // 72
            4'd1:    r = 31'd1636178018;  // 42
            4'd2:    r = 31'd1717986919;  // 20
            4'd3:    r = 31'd1431655766;  // 6
            4'd4:    r = 31'd1527099484;  // 90
            4'd5:    r = 31'd1227133514;  // 56
            4'd6:    r = 31'd1145324613;  // 30
            4'd7:    r = 31'd1431655766;  // 12
            4'd8:    r = 31'd1073741824;  // 2
            default: r = 31'd0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] div_shift(input logic [3:0] k);
        logic [5:0] s;
        unique case (k)
            4'd0:    s = 6'd37;
            4'd1:    s = 6'd36;
            4'd2:    s = 6'd35;
            4'd3:    s = 6'd33;
            4'd4:    s = 6'd37;
            4'd5:    s = 6'd36;
            4'd6:    s = 6'd35;
            4'd7:    s = 6'd34;
            4'd8:    s = 6'd31;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

    // one horner stage: p = 1 - ((t2 * p) >> 30) / d
    function automatic uop_t stage_uop(input logic [1:0] ph, input logic [3:0] k);
        uop_t u;
        u = UOP_IDLE;
        unique case (ph)
            2'd0: u.mul = MS_PX;
            2'd1: u.wb  = WB_X;
            2'd2:
            begin
                u.mul = MS_DIV;
                u.ma  = k;
            end
            2'd3:
            begin
                u.wb = WB_P;
                u.wi = k;
            end
            default: u = UOP_IDLE;
        endcase
        return u;
    endfunction

    // new = m * old, twelve products, overlapped issue and accumulate
    function automatic uop_t comp_uop(input logic [3:0] s);
        uop_t       u;
        logic [3:0] k;
        logic [2:0] e;
        logic       row;
        logic       half;
        logic [1:0] col;
        u = UOP_IDLE;
        if (s < 4'd12)
        begin
            k    = s;
            e    = k[3:1];
            half = k[0];
            row  = (e >= 3'd3);
            col  = row ? 2'(e - 3'd3) : e[1:0];
            u.mul = MS_MAT;
            u.ma  = 4'(row ? 3 : 0) + 4'(half);
            u.mb  = 3'(col) + (half ? 3'd3 : 3'd0);
        end
        if (s >= 4'd1 && s <= 4'd12)
        begin
            k    = s - 4'd1;
            u.wb = k[0] ? WB_RES : WB_ACC0;
            u.wi = {1'b0, k[3:1]};
        end
        if (s == 4'd13)
        begin
            u.wb   = WB_COMMIT;
            u.last = 1'b1;
        end
        return u;
    endfunction

    function automatic uop_t point_uop(input logic [2:0] s);
        uop_t       u;
        logic [1:0] k;
        u = UOP_IDLE;
        k = 2'd0;
        if (s < 3'd4)
        begin
            k     = s[1:0];
            u.mul = MS_MAT;
            u.ma  = k[0] ? MA_OPY : MA_OPX;
            u.mb  = (k[1] ? 3'd3 : 3'd0) + 3'(k[0]);
        end
        if (s >= 3'd1)
        begin
            k    = 2'(s - 3'd1);
            u.wb = k[0] ? WB_OUT : WB_ACC0;
            u.wi = {3'd0, k[1]};
        end
        if (s == 3'd4)
        begin
            u.last = 1'b1;
        end
        return u;
    endfunction

    function automatic uop_t rot_uop(input logic [STEP_W-1:0] s);
        uop_t              u;
        logic [STEP_W-1:0] o;
        u = UOP_IDLE;
        o = '0;
        priority if (s == 6'd0)
            u.mul = MS_T;
        else if (s == 6'd1)
            u.wb = WB_T;
        else if (s == 6'd2)
            u.mul = MS_T2;
        else if (s == 6'd3)
            u.wb = WB_T2;
        else if (s < 6'd20)
        begin
            o = s - 6'd4;
            u = stage_uop(o[1:0], SIN_DIV0 + 4'(o[5:2]));
        end
        else if (s == 6'd20)
            u.mul = MS_S;
        else if (s == 6'd21)
            u.wb = WB_SIN;
        else if (s < 6'd42)
        begin
            o = s - 6'd22;
            u = stage_uop(o[1:0], COS_DIV0 + 4'(o[5:2]));
        end
        else if (s == 6'd42)
            u.wb = WB_ROT;
        else
        begin
            o = s - 6'd43;
            u = comp_uop(o[3:0]);
        end
        return u;
    endfunction

    function automatic uop_t ucode(input logic [ACTION_W-1:0] act,
                                   input logic [STEP_W-1:0] s);
        uop_t u;
        u = UOP_IDLE;
        unique case (act)
            ACT_IDENT:
            begin
                u.wb   = WB_IDENT;
                u.last = 1'b1;
            end
            ACT_TRANSLATE, ACT_SCALE, ACT_COMPOSE: u = comp_uop(s[3:0]);
            ACT_ROTATE:                            u = rot_uop(s);
            ACT_POINT:                             u = point_uop(s[2:0]);
            default:                               u.last = 1'b1;
        endcase
        return u;
    endfunction

endpackage

// ----- rtl/aff_in_if.sv -----
interface aff_in_if import aff_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [ANGLE_W-1:0]         angle_turns;
    logic signed [DATA_W-1:0]   operand_x;
    logic signed [DATA_W-1:0]   operand_y;
    logic signed [DATA_W-1:0]   m_xx;
    logic signed [DATA_W-1:0]   m_xy;
    logic signed [DATA_W-1:0]   m_tx;
    logic signed [DATA_W-1:0]   m_yx;
    logic signed [DATA_W-1:0]   m_yy;
    logic signed [DATA_W-1:0]   m_ty;

    modport source (
        output valid, action, angle_turns, operand_x, operand_y,
               m_xx, m_xy, m_tx, m_yx, m_yy, m_ty,
        input  ready
    );

    modport sink (
        input  valid, action, angle_turns, operand_x, operand_y,
               m_xx, m_xy, m_tx, m_yx, m_yy, m_ty,
        output ready
    );
endinterface

// ----- rtl/aff_out_if.sv -----
interface aff_out_if import aff_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;

    modport source (
        output valid, out_x, out_y,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y,
        output ready
    );
endinterface

// ----- rtl/aff_ctrl.sv -----
module aff_ctrl import aff_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    output dp_cmd_t             cmd,
    input  dp_status_t          status
);

    ctrl_state_t         state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ACTION_W-1:0] act_reg, act_next;
    uop_t                uop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            act_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            act_reg   <= act_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        act_next   = act_reg;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.push   = 1'b0;
        cmd.uop    = UOP_IDLE;
        uop        = ucode(act_reg, step_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    act_next   = action;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.uop = uop;
                if (uop.last)
                    state_next = (act_reg == ACT_POINT) ? ST_PUSH : ST_IDLE;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_PUSH:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // no micro-program runs past MAX_STEP, the last step of the longest one
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= MAX_STEP))
        else $error("micro-program ran past its last step");

    // a result is only pushed into a free output register
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> status.out_free)
        else $error("result pushed over a pending result");

    // only a point request waits to hand off a result
    a_push_point: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> (act_reg == ACT_POINT))
        else $error("push state entered without a point request");

    // no datapath work overlaps a new load
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (cmd.uop.mul == MS_NONE && cmd.uop.wb == WB_NONE))
        else $error("load issued during datapath work");

endmodule

// ----- rtl/aff_dp.sv -----
module aff_dp import aff_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COEF_WIDTH = 32,
    parameter int ANGLE_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic [ACTION_W-1:0]      action,
    input  logic [ANGLE_W-1:0]       angle_turns,
    input  logic signed [DATA_W-1:0] operand_x,
    input  logic signed [DATA_W-1:0] operand_y,
    input  logic signed [DATA_W-1:0] m_xx,
    input  logic signed [DATA_W-1:0] m_xy,
    input  logic signed [DATA_W-1:0] m_tx,
    input  logic signed [DATA_W-1:0] m_yx,
    input  logic signed [DATA_W-1:0] m_yy,
    input  logic signed [DATA_W-1:0] m_ty,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_x,
    output logic signed [DATA_W-1:0] out_y
);

    localparam int MW    = (COEF_WIDTH > 34) ? COEF_WIDTH : 34;
    localparam int PW    = 2 * MW;
    localparam int ACC_W = PW + 2;

    localparam logic signed [DATA_W-1:0] ONE_M = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [COEF_WIDTH-1:0] ONE_C = (FRAC_BITS <= COEF_WIDTH - 2) ?
        (COEF_WIDTH'(1) << FRAC_BITS) : {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W:0] HALF = (ACC_W+1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W:0] CMAX = (ACC_W+1)'({(COEF_WIDTH-1){1'b1}});
    localparam logic signed [ACC_W:0] CMIN = ~CMAX;
    localparam logic signed [ACC_W:0] OMAX = (ACC_W+1)'({(DATA_W-1){1'b1}});
    localparam logic signed [ACC_W:0] OMIN = ~OMAX;
    localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-2:0] EIGHTH  = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 3);

    logic signed [COEF_WIDTH-1:0] mat_reg [6];
    logic signed [COEF_WIDTH-1:0] res_reg [6];
    logic signed [DATA_W-1:0]     nm_reg  [6];
    logic signed [DATA_W-1:0]     opx_reg, opy_reg;
    logic [ANGLE_W-1:0]           angle_reg;
    logic [Q30_W-1:0]             t_reg, t2_reg, x_reg, p_reg, s_reg;
    logic signed [PW-1:0]         prod_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic signed [DATA_W-1:0]     ptx_reg, pty_reg, out_x_reg, out_y_reg;
    logic                         out_valid_reg;

    logic [ANGLE_BITS-1:0]    ang;
    logic [ANGLE_BITS-2:0]    r_ext, rsel;
    logic                     swap;
    logic [1:0]               quad;
    logic [Q30_W-1:0]         sv, cv;
    logic signed [DATA_W-1:0] sf, cf, sn, cs;
    logic signed [MW-1:0]     mul_a, mul_b;
    logic [PW-1:0]            prod_u;
    logic [Q30_W-1:0]         p_new;
    logic signed [ACC_W-1:0]  term, sum;
    logic signed [ACC_W:0]    rounded;
    logic signed [COEF_WIDTH-1:0] sat_c;
    logic signed [DATA_W-1:0] sat_o;

    function automatic logic signed [DATA_W-1:0] q30_frac(input logic [Q30_W-1:0] v);
        logic [DATA_W-1:0] w;
        w = DATA_W'(v) + (DATA_W'(1) << (29 - FRAC_BITS));
        return signed'(w >> (30 - FRAC_BITS));
    endfunction

    // angle reduced to an octant
    assign ang   = ANGLE_BITS'(angle_reg);
    assign quad  = ang[ANGLE_BITS-1:ANGLE_BITS-2];
    assign r_ext = {1'b0, ang[ANGLE_BITS-3:0]};
    assign swap  = (r_ext > EIGHTH);
    assign rsel  = swap ? (QUARTER - r_ext) : r_ext;

    assign sv = swap ? p_reg : s_reg;
    assign cv = swap ? s_reg : p_reg;
    assign sf = q30_frac(sv);
    assign cf = q30_frac(cv);

    always_comb
    begin
        unique case (quad)
            2'd0:
            begin
                sn = sf;
                cs = cf;
            end
            2'd1:
            begin
                sn = cf;
                cs = -sf;
            end
            2'd2:
            begin
                sn = -sf;
                cs = -cf;
            end
            default:
            begin
                sn = -cf;
                cs = sf;
            end
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.uop.mul)
            MS_NONE: ;
            MS_T:
            begin
                mul_a = MW'(rsel);
                mul_b = MW'(TWO_PI_Q30);
            end
            MS_T2:
            begin
                mul_a = MW'(t_reg);
                mul_b = MW'(t_reg);
            end
            MS_PX:
            begin
                mul_a = MW'(t2_reg);
                mul_b = MW'(p_reg);
            end
            MS_DIV:
            begin
                mul_a = MW'(x_reg);
                mul_b = MW'(recip(cmd.uop.ma));
            end
            MS_S:
            begin
                mul_a = MW'(t_reg);
                mul_b = MW'(p_reg);
            end
            MS_MAT:
            begin
                if (cmd.uop.ma == MA_OPX)
                    mul_a = MW'(opx_reg);
                else if (cmd.uop.ma == MA_OPY)
                    mul_a = MW'(opy_reg);
                else
                    mul_a = MW'(nm_reg[cmd.uop.ma[2:0]]);
                mul_b = MW'(mat_reg[cmd.uop.mb]);
            end
            default: ;
        endcase
    end

    assign prod_u = prod_reg;
    assign p_new  = Q30_ONE - Q30_W'(prod_u >> div_shift(cmd.uop.wi));

    // translation column term, then round half up and saturate
    always_comb
    begin
        term = '0;
        if (cmd.uop.wb == WB_RES)
        begin
            if (cmd.uop.wi == 4'd2)
                term = ACC_W'(nm_reg[2]) <<< FRAC_BITS;
            else if (cmd.uop.wi == 4'd5)
                term = ACC_W'(nm_reg[5]) <<< FRAC_BITS;
        end
        else if (cmd.uop.wb == WB_OUT)
        begin
            term = cmd.uop.wi[0] ? (ACC_W'(mat_reg[5]) <<< FRAC_BITS)
                                 : (ACC_W'(mat_reg[2]) <<< FRAC_BITS);
        end
    end

    assign sum     = acc_reg + ACC_W'(prod_reg) + term;
    assign rounded = ((ACC_W+1)'(sum) + HALF) >>> FRAC_BITS;

    always_comb
    begin
        if (rounded > CMAX)
            sat_c = CMAX[COEF_WIDTH-1:0];
        else if (rounded < CMIN)
            sat_c = CMIN[COEF_WIDTH-1:0];
        else
            sat_c = rounded[COEF_WIDTH-1:0];
        if (rounded > OMAX)
            sat_o = OMAX[DATA_W-1:0];
        else if (rounded < OMIN)
            sat_o = OMIN[DATA_W-1:0];
        else
            sat_o = rounded[DATA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            angle_reg <= angle_turns;
            opx_reg   <= operand_x;
            opy_reg   <= operand_y;
            case (action)
                ACT_TRANSLATE:
                begin
                    nm_reg[0] <= ONE_M;
                    nm_reg[1] <= '0;
                    nm_reg[2] <= operand_x;
                    nm_reg[3] <= '0;
                    nm_reg[4] <= ONE_M;
                    nm_reg[5] <= operand_y;
                end
                ACT_SCALE:
                begin
                    nm_reg[0] <= operand_x;
                    nm_reg[1] <= '0;
                    nm_reg[2] <= '0;
                    nm_reg[3] <= '0;
                    nm_reg[4] <= operand_y;
                    nm_reg[5] <= '0;
                end
                ACT_COMPOSE:
                begin
                    nm_reg[0] <= m_xx;
                    nm_reg[1] <= m_xy;
                    nm_reg[2] <= m_tx;
                    nm_reg[3] <= m_yx;
                    nm_reg[4] <= m_yy;
                    nm_reg[5] <= m_ty;
                end
                default: ;
            endcase
        end
        if (cmd.uop.mul != MS_NONE)
            prod_reg <= mul_a * mul_b;
        unique case (cmd.uop.wb)
            WB_T:    t_reg  <= prod_reg[ANGLE_BITS +: Q30_W];
            WB_T2:
            begin
                t2_reg <= prod_reg[Q30_FRAC +: Q30_W];
                p_reg  <= Q30_ONE;
            end
            WB_X:    x_reg  <= prod_reg[Q30_FRAC +: Q30_W];
            WB_P:    p_reg  <= p_new;
            WB_SIN:
            begin
                s_reg <= prod_reg[Q30_FRAC +: Q30_W];
                p_reg <= Q30_ONE;
            end
            WB_ROT:
            begin
                nm_reg[0] <= cs;
                nm_reg[1] <= -sn;
                nm_reg[2] <= '0;
                nm_reg[3] <= sn;
                nm_reg[4] <= cs;
                nm_reg[5] <= '0;
            end
            WB_ACC0: acc_reg <= ACC_W'(prod_reg);
            WB_RES:  res_reg[cmd.uop.wi[2:0]] <= sat_c;
            WB_OUT:
            begin
                if (cmd.uop.wi[0])
                    pty_reg <= sat_o;
                else
                    ptx_reg <= sat_o;
            end
            default: ;
        endcase
        if (cmd.push)
        begin
            out_x_reg <= ptx_reg;
            out_y_reg <= pty_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
                mat_reg[i] <= (i == 0 || i == 4) ? ONE_C : '0;
        end
        else
        begin
            if (cmd.push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.uop.wb == WB_COMMIT)
            begin
                for (int i = 0; i < 6; i++)
                    mat_reg[i] <= res_reg[i];
            end
            else if (cmd.uop.wb == WB_IDENT)
            begin
                for (int i = 0; i < 6; i++)
                    mat_reg[i] <= (i == 0 || i == 4) ? ONE_C : '0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_x           = out_x_reg;
    assign out_y           = out_y_reg;

endmodule

// ----- rtl/affine_transform_2d_engine.sv -----
// 2d affine transform engine: keeps the top two rows of a 3x3 matrix in signed
// fixed point (FRAC_BITS fraction bits, COEF_WIDTH bits per entry) and takes one
// request at a time. reset identity sets the stored matrix to identity; translate,
// rotate (angle in turns), scale and compose each multiply a new matrix onto the
// stored one from the left, so the new transform acts after the earlier ones; map
// point returns the mapped point rounded half up and saturated to 32 bits. all
// work goes through one shared signed multiplier with a registered product,
// sequenced by a small micro-program. identity and unused action codes use no
// multiplier; translate / scale / compose issue twelve products, overlapped with
// accumulation; rotate computes sin and cos from horner polynomials whose
// dependent steps each take two multiplier passes, then runs the compose; map point
// may wait for the output register to free up before it hands off its result.
// out of reset the matrix is identity; no clearing pass is needed
module affine_transform_2d_engine import aff_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COEF_WIDTH = 32,
    parameter int ANGLE_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    aff_in_if.sink    in_ch,
    aff_out_if.source out_ch
);

    // command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: accepts a request when idle, then steps its micro-program
    aff_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .action   (in_ch.action),
        .cmd      (cmd),
        .status   (status)
    );

    // datapath: matrix state, shared multiplier, sin / cos unit, result register
    aff_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .COEF_WIDTH (COEF_WIDTH),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .action      (in_ch.action),
        .angle_turns (in_ch.angle_turns),
        .operand_x   (in_ch.operand_x),
        .operand_y   (in_ch.operand_y),
        .m_xx        (in_ch.m_xx),
        .m_xy        (in_ch.m_xy),
        .m_tx        (in_ch.m_tx),
        .m_yx        (in_ch.m_yx),
        .m_yy        (in_ch.m_yy),
        .m_ty        (in_ch.m_ty),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_x       (out_ch.out_x),
        .out_y       (out_ch.out_y)
    );

endmodule
